// ----- rtl/core/scaw_pkg.sv -----
// ----------------------------------------------------------------------------
// scaw_pkg
// Types and constants for the six-channel low-pass filter with angle unwrap.
// ----------------------------------------------------------------------------
package scaw_pkg;

  // Channel layout
  localparam int NumChannels = 6;
  localparam int WrapFirst   = 3;

  // Gain is Q1.15, product is scaled back by this many bits
  localparam int GainShift   = 15;

  // Gain after reset (15 Hz at the nominal sample period)
  localparam logic [15:0] GainReset = 16'd5197;

  // Q16.16 angle constants
  localparam logic signed [32:0] WrapThreshold = 33'sd308831;  // 1.5*pi
  localparam logic signed [33:0] TwoPiQ16      = 34'sd411775;  // 2*pi

  // Saturation limits of a Q16.16 sample
  localparam logic signed [35:0] SampleMax = 36'sd2147483647;
  localparam logic signed [35:0] SampleMin = -36'sd2147483648;

  // Input transaction payload
  typedef struct packed {
    logic signed [31:0] sample_0;
    logic signed [31:0] sample_1;
    logic signed [31:0] sample_2;
    logic signed [31:0] sample_3;
    logic signed [31:0] sample_4;
    logic signed [31:0] sample_5;
    logic               check_wrap;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic signed [31:0] smooth_0;
    logic signed [31:0] smooth_1;
    logic signed [31:0] smooth_2;
    logic signed [31:0] smooth_3;
    logic signed [31:0] smooth_4;
    logic signed [31:0] smooth_5;
  } out_item_t;

  typedef logic signed [31:0] sample_t;

endpackage

// ----- rtl/core/six_channel_lowpass_angle_wrap_unit.sv -----
// ----------------------------------------------------------------------------
// six_channel_lowpass_angle_wrap_unit
// First-order low-pass filter over a six-channel Q16.16 vector, with 2*pi
// unwrap on the three angle channels.
// ----------------------------------------------------------------------------
// One transaction per clock is accepted and one result per clock is produced
// while the result side does not stall. The input register feeds six
// parallel filter lanes (one 17x33 multiply each) that write the filter
// state and the result register (out_data) as the input register advances.
// Because the filter state is written together with the result register,
// consecutive samples need no spacing. A stall on the result side holds the
// result register and one more transaction in the input register, after
// which in_stall rises. The first transaction after reset seeds the state
// and passes the samples through. The gain register may be written only
// while no transaction is in flight.
module six_channel_lowpass_angle_wrap_unit (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  scaw_pkg::in_item_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output scaw_pkg::out_item_t out_data,
  // gain register write
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);
  import scaw_pkg::*;

  // Clamp a wide signed value to the int32 range
  function automatic sample_t sat_s32(input logic signed [35:0] v);
    sample_t r;
    if (v > SampleMax) begin
      r = 32'sh7fffffff;
    end else if (v < SampleMin) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // One filter lane: optional unwrap of y, then y + floor(gain*(x-y) / 2^15)
  function automatic sample_t filt_step(input sample_t     x,
                                        input sample_t     y,
                                        input logic [15:0] gain,
                                        input logic        wrap);
    logic signed [32:0] d;
    logic signed [33:0] y_ext;
    sample_t            y_w;
    logic signed [49:0] prod;
    logic signed [34:0] inc;
    logic signed [35:0] sum;
    d     = $signed({x[31], x}) - $signed({y[31], y});
    y_ext = $signed({{2{y[31]}}, y});
    y_w   = y;
    if (wrap && (d > WrapThreshold)) begin
      y_w = sat_s32(36'(y_ext) + 36'(TwoPiQ16));
    end else if (wrap && (d < -WrapThreshold)) begin
      y_w = sat_s32(36'(y_ext) - 36'(TwoPiQ16));
    end
    d    = $signed({x[31], x}) - $signed({y_w[31], y_w});
    prod = $signed({1'b0, gain}) * d;
    // arithmetic shift = floor division
    inc  = prod[49:GainShift];
    sum  = $signed({{4{y_w[31]}}, y_w}) + $signed({inc[34], inc});
    return sat_s32(sum);
  endfunction

  // Registers
  logic        s1_valid_r;
  in_item_t    s1_data_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic [15:0] gain_r;
  logic        seeded_r;
  sample_t     y_r   [NumChannels];
  sample_t     y_nxt [NumChannels];
  sample_t     x_arr [NumChannels];
  out_item_t   out_data_nxt;

  logic out_free;
  logic s1_adv;

  // Handshake: result register drains or is empty -> stage 1 moves on
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Unpack registered samples
  always_comb begin
    x_arr[0] = s1_data_r.sample_0;
    x_arr[1] = s1_data_r.sample_1;
    x_arr[2] = s1_data_r.sample_2;
    x_arr[3] = s1_data_r.sample_3;
    x_arr[4] = s1_data_r.sample_4;
    x_arr[5] = s1_data_r.sample_5;
  end

  // Filter lanes; first transaction after reset seeds the state
  for (genvar ch = 0; ch < NumChannels; ch++) begin : g_lane
    localparam logic IsAngle = (ch >= WrapFirst);
    always_comb begin
      if (!seeded_r) begin
        y_nxt[ch] = x_arr[ch];
      end else begin
        y_nxt[ch] = filt_step(x_arr[ch], y_r[ch], gain_r,
                              s1_data_r.check_wrap & IsAngle);
      end
    end
  end

  // Pack result
  always_comb begin
    out_data_nxt.smooth_0 = y_nxt[0];
    out_data_nxt.smooth_1 = y_nxt[1];
    out_data_nxt.smooth_2 = y_nxt[2];
    out_data_nxt.smooth_3 = y_nxt[3];
    out_data_nxt.smooth_4 = y_nxt[4];
    out_data_nxt.smooth_5 = y_nxt[5];
  end

  // Control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      gain_r      <= GainReset;
      seeded_r    <= 1'b0;
      for (int i = 0; i < NumChannels; i++) begin
        y_r[i] <= '0;
      end
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        seeded_r <= 1'b1;
        for (int i = 0; i < NumChannels; i++) begin
          y_r[i] <= y_nxt[i];
        end
      end
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
